@@ rtl/gmt_pkg.sv @@
`timescale 1ns / 1ps
package gmt_pkg;
	localparam int CoordW = 24;
	localparam int CountW = 7;
	localparam int RowW = 6;
	localparam int ColW = 6;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 7;
	localparam int DefMaxRows = 64;
	localparam int DefMaxColumns = 64;

	localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_COLUMN_COUNT = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_WRAP_MODE = 2'd2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_GENERATE = 1'b1;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		logic command;
		logic [RowW-1:0] row;
		logic [ColW-1:0] column;
		coord_t coord_x;
		coord_t coord_y;
		coord_t coord_z;
	} in_item_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		coord_t normal_x;
		coord_t normal_y;
		coord_t normal_z;
		logic last;
		logic error;
	} out_item_t;

	// normalize unit operation codes
	typedef enum logic [1:0] {
		NOP_IDLE,
		NOP_SQRT,
		NOP_DIV
	} nu_phase_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RD_A,
		ST_RD_B,
		ST_RD_E,
		ST_RD_B2,
		ST_RD_WAIT,
		ST_NORM_B,
		ST_WAIT_B,
		ST_NORM_E,
		ST_WAIT_E,
		ST_NORM_B2,
		ST_WAIT_B2,
		ST_CROSS1,
		ST_CROSS2,
		ST_EMIT,
		ST_ERR
	} state_t;
endpackage

@@ rtl/gmt_if.sv @@
`timescale 1ns / 1ps
interface gmt_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/gmt_norm.sv @@
`timescale 1ns / 1ps
// normalizes a 25-bit difference vector: iterative root, then three
// bit-serial divisions, one result bit per cycle
module gmt_norm (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [24:0] dx,
	input logic signed [24:0] dy,
	input logic signed [24:0] dz,
	output logic done,
	output logic signed [17:0] nx,
	output logic signed [17:0] ny,
	output logic signed [17:0] nz
);
	import gmt_pkg::*;

	// len * 4096 fits in 64 bits; root is 32 bits
	logic [1:0] phase_q;
	logic [63:0] rad_q;
	logic [31:0] root_q;
	logic [65:0] rem_q;
	logic [5:0] cnt_q;
	logic [1:0] comp_q;
	logic [24:0] mag_q [3];
	logic sgn_q [3];
	logic [49:0] num_q;
	logic [33:0] drem_q;
	logic [17:0] quo_q;
	logic signed [17:0] res_q [3];
	logic [49:0] len_w;
	logic [49:0] sq_x, sq_y, sq_z;
	logic [24:0] ax, ay, az;
	logic [65:0] trial;
	logic [33:0] dshift;
	logic [33:0] den2;

	assign ax = dx[24] ? 25'(-dx) : 25'(dx);
	assign ay = dy[24] ? 25'(-dy) : 25'(dy);
	assign az = dz[24] ? 25'(-dz) : 25'(dz);
	// squared length from the component magnitudes
	assign sq_x = ax * ax;
	assign sq_y = ay * ay;
	assign sq_z = az * az;
	assign len_w = sq_x + sq_y + sq_z;

	assign trial = {rem_q[63:0], rad_q[63:62]} - {32'd0, root_q, 2'b01};
	// q = floor((2*mag*2^22 + s) / (2s)): divide (mag<<23 + s) by 2s
	assign den2 = {1'b0, root_q, 1'b0};
	assign dshift = {drem_q[32:0], num_q[49]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= NOP_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (phase_q)
				NOP_IDLE: begin
					if (start) begin
						mag_q[0] <= ax; mag_q[1] <= ay; mag_q[2] <= az;
						sgn_q[0] <= dx[24]; sgn_q[1] <= dy[24]; sgn_q[2] <= dz[24];
						if (len_w == 50'd0) begin
							res_q[0] <= '0; res_q[1] <= '0; res_q[2] <= '0;
							done <= 1'b1;
						end else begin
							rad_q <= {2'b00, len_w, 12'd0};
							root_q <= '0;
							rem_q <= '0;
							cnt_q <= 6'd0;
							phase_q <= NOP_SQRT;
						end
					end
				end
				NOP_SQRT: begin
					// one root bit per cycle
					if (!trial[65]) begin
						rem_q <= trial;
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[63:0], rad_q[63:62]};
						root_q <= {root_q[30:0], 1'b0};
					end
					rad_q <= {rad_q[61:0], 2'b00};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						phase_q <= NOP_DIV;
						comp_q <= 2'd0;
						cnt_q <= 6'd0;
					end
				end
				NOP_DIV: begin
					if (cnt_q == 6'd0) begin
						num_q <= {2'd0, mag_q[comp_q], 23'd0} + 50'(root_q);
						drem_q <= '0;
						quo_q <= '0;
						cnt_q <= 6'd1;
					end else begin
						if (dshift >= den2) begin
							drem_q <= dshift - den2;
							quo_q <= {quo_q[16:0], 1'b1};
						end else begin
							drem_q <= dshift;
							quo_q <= {quo_q[16:0], 1'b0};
						end
						num_q <= {num_q[48:0], 1'b0};
						cnt_q <= cnt_q + 6'd1;
						if (cnt_q == 6'd50) begin
							res_q[comp_q] <= sgn_q[comp_q] ?
								-$signed({1'b0, quo_q[15:0], (dshift >= den2)}) :
								$signed({1'b0, quo_q[15:0], (dshift >= den2)});
							cnt_q <= 6'd0;
							if (comp_q == 2'd2) begin
								phase_q <= NOP_IDLE;
								done <= 1'b1;
							end else begin
								comp_q <= comp_q + 2'd1;
							end
						end
					end
				end
				default: phase_q <= NOP_IDLE;
			endcase
		end
	end

	assign nx = res_q[0];
	assign ny = res_q[1];
	assign nz = res_q[2];
endmodule

@@ rtl/grid_mesh_triangulator.sv @@
`timescale 1ns / 1ps
// Grid mesh triangulator. Write requests store a vertex and give no result;
// out-of-range requests give one error record. A generate request reads
// four vertices in turn through the one read port of the vertex store, then
// normalizes two or three vectors in one shared unit (a square root,
// then three divisions, per edge), forms the cross products through one
// shared multiplier, and emits six records, one per cycle when the sink is
// ready. Only one request is in flight; the last record may still wait in
// the output register while the next request is taken. The vertex store is
// not cleared and must be written before a cell that uses it is generated.
module grid_mesh_triangulator #(
	parameter int MAX_ROWS = gmt_pkg::DefMaxRows,
	parameter int MAX_COLUMNS = gmt_pkg::DefMaxColumns
) (
	input logic clk,
	input logic arst_n,
	gmt_if.sink in_ch,
	gmt_if.source out_ch,
	input logic cfg_we,
	input logic [gmt_pkg::CfgIdxW-1:0] cfg_index,
	input logic [gmt_pkg::CfgDataW-1:0] cfg_data
);
	import gmt_pkg::*;

	localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CAW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int Depth = MAX_ROWS * MAX_COLUMNS;
	localparam int AW = $clog2(Depth);

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vtx_t;

	state_t state_q, state_d;
	logic [CountW-1:0] row_count_q, column_count_q;
	logic wrap_q;
	in_item_t req_q;
	vtx_t mem [Depth];
	vtx_t rd_s1;
	vtx_t va_q, vb_q, ve_q, vb2_q;
	logic [CountW-1:0] rows_w, cols_w;
	logic [CountW-1:0] r_w, c_w, nr_w, nc_w;
	logic [RAW-1:0] nr_q;
	logic [CAW-1:0] nc_q;
	logic [1:0] rd_slot_q;
	logic rd_pend_q;
	logic bad_w;
	logic [AW-1:0] rd_addr;
	logic mem_re;
	logic norm_start;
	logic norm_done;
	logic signed [24:0] ndx, ndy, ndz;
	logic signed [17:0] nox, noy, noz;
	logic signed [17:0] nb_q [3];
	logic signed [17:0] ne_q [3];
	logic signed [17:0] nb2_q [3];
	coord_t n1_q [3];
	coord_t n2_q [3];
	logic signed [17:0] ua [3];
	logic signed [17:0] ub [3];
	logic [2:0] xstep_q;
	logic signed [36:0] prod_s1;
	logic signed [37:0] acc_q;
	logic [2:0] emit_q;
	logic ov_q;
	logic ld_w;
	out_item_t ob_q;
	vtx_t epos;

	// counts clamped to the store size
	assign rows_w = (int'(row_count_q) > MAX_ROWS) ? CountW'(MAX_ROWS) : row_count_q;
	assign cols_w = (int'(column_count_q) > MAX_COLUMNS) ?
		CountW'(MAX_COLUMNS) : column_count_q;
	assign r_w = CountW'(req_q.row);
	assign c_w = CountW'(req_q.column);
	assign nr_w = (wrap_q && (r_w + 7'd1 == rows_w)) ? '0 : r_w + 7'd1;
	assign nc_w = (wrap_q && (c_w + 7'd1 == cols_w)) ? '0 : c_w + 7'd1;

	always_comb begin
		if (req_q.command == CMD_WRITE || wrap_q)
			bad_w = (r_w >= rows_w) || (c_w >= cols_w);
		else
			bad_w = (r_w + 7'd1 >= rows_w) || (c_w + 7'd1 >= cols_w);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 7'd64;
			column_count_q <= 7'd64;
			wrap_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW_COUNT: row_count_q <= cfg_data;
				CFG_COLUMN_COUNT: column_count_q <= cfg_data;
				CFG_WRAP_MODE: wrap_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// read address per fetch state
	always_comb begin
		mem_re = 1'b1;
		case (state_q)
			ST_RD_A: rd_addr = AW'(RAW'(req_q.row) * MAX_COLUMNS + CAW'(req_q.column));
			ST_RD_B: rd_addr = AW'(nr_q * MAX_COLUMNS + CAW'(req_q.column));
			ST_RD_E: rd_addr = AW'(nr_q * MAX_COLUMNS + nc_q);
			ST_RD_B2: rd_addr = AW'(RAW'(req_q.row) * MAX_COLUMNS + nc_q);
			default: begin
				rd_addr = '0;
				mem_re = 1'b0;
			end
		endcase
	end

	// vertex store
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK && !bad_w && req_q.command == CMD_WRITE)
			mem[AW'(RAW'(req_q.row) * MAX_COLUMNS + CAW'(req_q.column))] <=
				{req_q.coord_x, req_q.coord_y, req_q.coord_z};
		if (mem_re)
			rd_s1 <= mem[rd_addr];
	end

	// normalize operand select
	always_comb begin
		case (state_q)
			ST_NORM_B: begin
				ndx = 25'(vb_q.x) - 25'(va_q.x);
				ndy = 25'(vb_q.y) - 25'(va_q.y);
				ndz = 25'(vb_q.z) - 25'(va_q.z);
			end
			ST_NORM_E: begin
				ndx = 25'(ve_q.x) - 25'(va_q.x);
				ndy = 25'(ve_q.y) - 25'(va_q.y);
				ndz = 25'(ve_q.z) - 25'(va_q.z);
			end
			default: begin
				ndx = 25'(vb2_q.x) - 25'(va_q.x);
				ndy = 25'(vb2_q.y) - 25'(va_q.y);
				ndz = 25'(vb2_q.z) - 25'(va_q.z);
			end
		endcase
	end
	assign norm_start = (state_q == ST_NORM_B) || (state_q == ST_NORM_E) ||
		(state_q == ST_NORM_B2);

	gmt_norm u_norm (
		.clk(clk), .arst_n(arst_n), .start(norm_start),
		.dx(ndx), .dy(ndy), .dz(ndz),
		.done(norm_done), .nx(nox), .ny(noy), .nz(noz)
	);

	// cross product operands: first triangle uses the negated b edge
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ua[i] = (state_q == ST_CROSS1) ? 18'(-nb_q[i]) : nb2_q[i];
			ub[i] = ne_q[i];
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_ch.valid) state_d = ST_CHECK;
			ST_CHECK: begin
				if (bad_w) state_d = ST_ERR;
				else if (req_q.command == CMD_WRITE) state_d = ST_IDLE;
				else state_d = ST_RD_A;
			end
			ST_RD_A: state_d = ST_RD_B;
			ST_RD_B: state_d = ST_RD_E;
			ST_RD_E: state_d = ST_RD_B2;
			ST_RD_B2: state_d = ST_RD_WAIT;
			ST_RD_WAIT: state_d = ST_NORM_B;
			ST_NORM_B: state_d = ST_WAIT_B;
			ST_WAIT_B: if (norm_done) state_d = ST_NORM_E;
			ST_NORM_E: state_d = ST_WAIT_E;
			ST_WAIT_E: if (norm_done) state_d = wrap_q ? ST_NORM_B2 : ST_CROSS1;
			ST_NORM_B2: state_d = ST_WAIT_B2;
			ST_WAIT_B2: if (norm_done) state_d = ST_CROSS1;
			ST_CROSS1: if (xstep_q == 3'd6) state_d = wrap_q ? ST_CROSS2 : ST_EMIT;
			ST_CROSS2: if (xstep_q == 3'd6) state_d = ST_EMIT;
			ST_EMIT: if (emit_q == 3'd6) state_d = ST_IDLE;
			ST_ERR: if (!ov_q || out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign in_ch.ready = (state_q == ST_IDLE);

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) req_q <= in_ch.payload;
		if (state_q == ST_CHECK) begin
			nr_q <= RAW'(nr_w);
			nc_q <= CAW'(nc_w);
		end
		rd_pend_q <= mem_re;
		if (state_q == ST_RD_A) rd_slot_q <= 2'd0;
		else if (rd_pend_q) rd_slot_q <= rd_slot_q + 2'd1;
		if (rd_pend_q) begin
			case (rd_slot_q)
				2'd0: va_q <= rd_s1;
				2'd1: vb_q <= rd_s1;
				2'd2: ve_q <= rd_s1;
				default: vb2_q <= rd_s1;
			endcase
		end
		if (norm_done) begin
			case (state_q)
				ST_WAIT_B: begin nb_q[0] <= nox; nb_q[1] <= noy; nb_q[2] <= noz; end
				ST_WAIT_E: begin ne_q[0] <= nox; ne_q[1] <= noy; ne_q[2] <= noz; end
				default: begin nb2_q[0] <= nox; nb2_q[1] <= noy; nb2_q[2] <= noz; end
			endcase
		end
	end

	// shared multiplier: six products, two per component, then rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xstep_q <= '0;
		end else if (state_q == ST_CROSS1 || state_q == ST_CROSS2) begin
			xstep_q <= (xstep_q == 3'd6) ? 3'd0 : xstep_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [17:0] m0, m1;
		logic signed [36:0] p;
		logic [1:0] ci;
		logic [37:0] mag;
		logic [21:0] q;
		coord_t res;
		m0 = '0; m1 = '0;
		case (xstep_q)
			3'd0: begin m0 = ua[1]; m1 = ub[2]; end
			3'd1: begin m0 = ua[2]; m1 = ub[1]; end
			3'd2: begin m0 = ua[2]; m1 = ub[0]; end
			3'd3: begin m0 = ua[0]; m1 = ub[2]; end
			3'd4: begin m0 = ua[0]; m1 = ub[1]; end
			3'd5: begin m0 = ua[1]; m1 = ub[0]; end
			default: ;
		endcase
		p = m0 * m1;
		prod_s1 <= p;
		// odd steps start a component, even steps subtract
		if (xstep_q != 3'd0) begin
			ci = 2'((xstep_q - 3'd1) >> 1);
			if (xstep_q[0]) begin
				acc_q <= 38'(prod_s1);
			end else begin
				mag = (acc_q - 38'(prod_s1)) < 0 ?
					38'(-(acc_q - 38'(prod_s1))) : 38'(acc_q - 38'(prod_s1));
				q = 22'((mag + 38'd32768) >> 16);
				res = ((acc_q - 38'(prod_s1)) < 0) ? -coord_t'(q) : coord_t'(q);
				if (state_q == ST_CROSS1) begin
					n1_q[ci] <= res;
					n2_q[ci] <= res;
				end else begin
					n2_q[ci] <= res;
				end
			end
		end
	end

	// output register and emit counter
	always_comb begin
		case (emit_q)
			3'd0, 3'd3: epos = va_q;
			3'd1: epos = vb_q;
			3'd4: epos = vb2_q;
			default: epos = ve_q;
		endcase
	end

	// a record loads when the output register is free or being taken
	assign ld_w = (!ov_q || out_ch.ready) &&
		((state_q == ST_EMIT && emit_q != 3'd6) || state_q == ST_ERR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			emit_q <= '0;
		end else begin
			if (ld_w) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
			if (state_q == ST_EMIT) begin
				if (emit_q == 3'd6) emit_q <= '0;
				else if (ld_w) emit_q <= emit_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_w) begin
			if (state_q == ST_ERR) begin
				ob_q.pos_x <= '0;
				ob_q.pos_y <= '0;
				ob_q.pos_z <= '0;
				ob_q.normal_x <= '0;
				ob_q.normal_y <= '0;
				ob_q.normal_z <= '0;
				ob_q.last <= 1'b1;
				ob_q.error <= 1'b1;
			end else begin
				ob_q.pos_x <= epos.x;
				ob_q.pos_y <= epos.y;
				ob_q.pos_z <= epos.z;
				ob_q.normal_x <= (emit_q < 3'd3) ? n1_q[0] : n2_q[0];
				ob_q.normal_y <= (emit_q < 3'd3) ? n1_q[1] : n2_q[1];
				ob_q.normal_z <= (emit_q < 3'd3) ? n1_q[2] : n2_q[2];
				ob_q.last <= (emit_q == 3'd5);
				ob_q.error <= 1'b0;
			end
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.payload = ob_q;
endmodule

@@ sim/tb_grid_mesh_triangulator.sv @@
`timescale 1ns / 1ps
module tb_grid_mesh_triangulator;
	import gmt_pkg::*;

	localparam int StoreCols = 64;
	localparam int CycleLimit = 1500000;
	localparam int DrainCycles = 16;
	localparam int HoldCycles = 1500;

	// predictor of the triangulator with its own vertex store and queue of records
	class mesh_scoreboard;
		longint vx[4096];
		longint vy[4096];
		longint vz[4096];
		int rows_used;
		int cols_used;
		bit wrap_on;
		out_item_t record_q[$];
		int records_checked;
		int cells_made;
		int error_records;

		function new();
			rows_used = 64;
			cols_used = 64;
			wrap_on = 1'b1;
			records_checked = 0;
			cells_made = 0;
			error_records = 0;
		endfunction

		function void set_config(int r, int c, bit w);
			rows_used = (r > 64) ? 64 : r;
			cols_used = (c > 64) ? 64 : c;
			wrap_on = w;
		endfunction

		function int pending();
			return record_q.size();
		endfunction

		function longint unsigned int_root(longint unsigned x);
			longint unsigned res;
			longint unsigned bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > x)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (x >= res + bitv) begin
					x = x - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		// nearest, ties away from zero
		function longint round_div(longint num, longint den);
			longint mag;
			longint q;
			mag = (num < 0) ? -num : num;
			q = (2 * mag + den) / (2 * den);
			return (num < 0) ? -q : q;
		endfunction

		function void unit_edge(int ia, int ib, output longint ux, output longint uy,
				output longint uz);
			longint dx;
			longint dy;
			longint dz;
			longint unsigned len;
			longint s;
			dx = vx[ib] - vx[ia];
			dy = vy[ib] - vy[ia];
			dz = vz[ib] - vz[ia];
			len = dx * dx + dy * dy + dz * dz;
			ux = 0;
			uy = 0;
			uz = 0;
			// zero-length edge stays the zero vector
			if (len != 0) begin
				s = longint'(int_root(len * 4096));
				ux = round_div(dx * (64'sd1 <<< 22), s);
				uy = round_div(dy * (64'sd1 <<< 22), s);
				uz = round_div(dz * (64'sd1 <<< 22), s);
			end
		endfunction

		function void cross3(longint ax, longint ay, longint az, longint bx, longint by,
				longint bz, output longint cx, output longint cy, output longint cz);
			cx = round_div(ay * bz - az * by, 65536);
			cy = round_div(az * bx - ax * bz, 65536);
			cz = round_div(ax * by - ay * bx, 65536);
		endfunction

		function void push_rec(int idx, longint nx, longint ny, longint nz, bit lst);
			out_item_t rec;
			rec.pos_x = coord_t'(vx[idx]);
			rec.pos_y = coord_t'(vy[idx]);
			rec.pos_z = coord_t'(vz[idx]);
			rec.normal_x = coord_t'(nx);
			rec.normal_y = coord_t'(ny);
			rec.normal_z = coord_t'(nz);
			rec.last = lst;
			rec.error = 1'b0;
			record_q.push_back(rec);
		endfunction

		function void push_error();
			out_item_t rec;
			rec = '0;
			rec.last = 1'b1;
			rec.error = 1'b1;
			record_q.push_back(rec);
			error_records++;
		endfunction

		function void note_request(in_item_t it);
			int r;
			int c;
			int nr;
			int nc;
			int ia;
			int ib;
			int ie;
			int ib2;
			longint bx, by, bz, ex, ey, ez, qx, qy, qz;
			longint n1x, n1y, n1z, n2x, n2y, n2z;
			r = it.row;
			c = it.column;
			// vertex write
			if (it.command == CMD_WRITE) begin
				if (r >= rows_used || c >= cols_used) begin
					push_error();
				end else begin
					vx[r * StoreCols + c] = it.coord_x;
					vy[r * StoreCols + c] = it.coord_y;
					vz[r * StoreCols + c] = it.coord_z;
				end
				return;
			end
			// cell range and neighbours
			if (wrap_on) begin
				if (r >= rows_used || c >= cols_used) begin
					push_error();
					return;
				end
				nr = (r + 1 == rows_used) ? 0 : r + 1;
				nc = (c + 1 == cols_used) ? 0 : c + 1;
			end else begin
				if (r + 1 >= rows_used || c + 1 >= cols_used) begin
					push_error();
					return;
				end
				nr = r + 1;
				nc = c + 1;
			end
			ia = r * StoreCols + c;
			ib = nr * StoreCols + c;
			ie = nr * StoreCols + nc;
			ib2 = r * StoreCols + nc;
			unit_edge(ia, ib, bx, by, bz);
			unit_edge(ia, ie, ex, ey, ez);
			cross3(-bx, -by, -bz, ex, ey, ez, n1x, n1y, n1z);
			n2x = n1x;
			n2y = n1y;
			n2z = n1z;
			if (wrap_on) begin
				unit_edge(ia, ib2, qx, qy, qz);
				cross3(qx, qy, qz, ex, ey, ez, n2x, n2y, n2z);
			end
			push_rec(ia, n1x, n1y, n1z, 1'b0);
			push_rec(ib, n1x, n1y, n1z, 1'b0);
			push_rec(ie, n1x, n1y, n1z, 1'b0);
			push_rec(ia, n2x, n2y, n2z, 1'b0);
			push_rec(ib2, n2x, n2y, n2z, 1'b0);
			push_rec(ie, n2x, n2y, n2z, 1'b1);
			cells_made++;
		endfunction

		// empty string when the record matches the oldest expectation
		function string check_record(out_item_t got);
			out_item_t want;
			string msg;
			if (record_q.size() == 0)
				return "record with nothing expected";
			want = record_q.pop_front();
			records_checked++;
			msg = "";
			if (got.pos_x !== want.pos_x) msg = {msg, " pos_x"};
			if (got.pos_y !== want.pos_y) msg = {msg, " pos_y"};
			if (got.pos_z !== want.pos_z) msg = {msg, " pos_z"};
			if (got.normal_x !== want.normal_x) msg = {msg, " normal_x"};
			if (got.normal_y !== want.normal_y) msg = {msg, " normal_y"};
			if (got.normal_z !== want.normal_z) msg = {msg, " normal_z"};
			if (got.last !== want.last) msg = {msg, " last"};
			if (got.error !== want.error) msg = {msg, " error"};
			if (msg != "")
				msg = $sformatf("record %0d wrong:%s got %h want %h", records_checked, msg,
					got, want);
			return msg;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	gmt_if #(.payload_t(in_item_t)) in_ch ();
	gmt_if #(.payload_t(out_item_t)) out_ch ();

	grid_mesh_triangulator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	mesh_scoreboard sb;
	int fails;
	int snd_idle;
	int rcv_idle;
	bit hold_req;
	int hold_left;
	int requests_sent;
	int cycles;
	int cur_rows;
	int cur_cols;
	bit cur_wrap;
	bit written [4096];

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL grid_mesh_triangulator");
		$finish;
	end

	task automatic report_mismatch(string msg);
		$display("mismatch: %s", msg);
		fails++;
	endtask

	// result side: check accepted records, then pick ready for the next cycle
	initial begin
		string msg;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				msg = sb.check_record(out_ch.payload);
				if (msg != "")
					report_mismatch(msg);
			end
			if (hold_req) begin
				hold_left = HoldCycles;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	// request side: optional gap, then hold valid until accepted
	task automatic send(in_item_t it);
		if ($urandom_range(99) < snd_idle) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_request(it);
		requests_sent++;
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(3))
			0: return coord_t'($urandom);
			1: return $urandom_range(1) ? coord_t'(24'h7fffff) : coord_t'(24'h800000);
			default: return coord_t'($urandom_range(4095)) - coord_t'(2048);
		endcase
	endfunction

	task automatic write_vertex(int r, int c, coord_t x, coord_t y, coord_t z);
		in_item_t it;
		it.command = CMD_WRITE;
		it.row = r[RowW-1:0];
		it.column = c[ColW-1:0];
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		send(it);
		if (r < cur_rows && c < cur_cols)
			written[r * StoreCols + c] = 1'b1;
	endtask

	task automatic generate_raw(int r, int c);
		in_item_t it;
		it.command = CMD_GENERATE;
		it.row = r[RowW-1:0];
		it.column = c[ColW-1:0];
		it.coord_x = rand_coord();
		it.coord_y = rand_coord();
		it.coord_z = rand_coord();
		send(it);
	endtask

	function automatic bit cell_ok(int r, int c);
		if (cur_wrap)
			return r < cur_rows && c < cur_cols;
		return r + 1 < cur_rows && c + 1 < cur_cols;
	endfunction

	// well-formed cell: fill any unwritten corner, rewrite some at random, then generate
	task automatic emit_cell(int r, int c);
		int nr;
		int nc;
		int rr [4];
		int cc [4];
		nr = (cur_wrap && r + 1 == cur_rows) ? 0 : r + 1;
		nc = (cur_wrap && c + 1 == cur_cols) ? 0 : c + 1;
		rr = '{r, nr, nr, r};
		cc = '{c, c, nc, nc};
		for (int k = 0; k < 4; k++)
			if (!written[rr[k] * StoreCols + cc[k]] || $urandom_range(9) == 0)
				write_vertex(rr[k], cc[k], rand_coord(), rand_coord(), rand_coord());
		generate_raw(r, c);
	endtask

	// let the block go idle before touching its registers
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_grid(int r, int c, bit w);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROW_COUNT;
		cfg_data <= r[CfgDataW-1:0];
		@(posedge clk);
		cfg_index <= CFG_COLUMN_COUNT;
		cfg_data <= c[CfgDataW-1:0];
		@(posedge clk);
		cfg_index <= CFG_WRAP_MODE;
		cfg_data <= CfgDataW'(w);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_rows = (r > 64) ? 64 : r;
		cur_cols = (c > 64) ? 64 : c;
		cur_wrap = w;
		sb.set_config(r, c, w);
	endtask

	// mostly well-formed cells, some stray writes and generates
	task automatic random_request();
		int k;
		int r;
		int c;
		k = $urandom_range(99);
		if (k < 65) begin
			r = cur_wrap ? $urandom_range(cur_rows - 1) : $urandom_range(cur_rows - 2);
			c = cur_wrap ? $urandom_range(cur_cols - 1) : $urandom_range(cur_cols - 2);
			emit_cell(r, c);
		end else if (k < 85) begin
			write_vertex($urandom_range(63), $urandom_range(63), rand_coord(), rand_coord(),
				rand_coord());
		end else begin
			r = $urandom_range(63);
			c = $urandom_range(63);
			if (cell_ok(r, c))
				emit_cell(r, c);
			else
				generate_raw(r, c);
		end
	endtask

	// stimulus
	initial begin
		int phase_rows [6];
		int phase_cols [6];
		bit phase_wrap [6];
		sb = new();
		fails = 0;
		requests_sent = 0;
		snd_idle = 0;
		rcv_idle = 0;
		hold_req = 1'b0;
		cur_rows = 64;
		cur_cols = 64;
		cur_wrap = 1'b1;
		phase_rows = '{64, 2, 127, 5, 64, 3};
		phase_cols = '{64, 2, 100, 7, 64, 64};
		phase_wrap = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.payload <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ROW_COUNT;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extreme coordinates on the first cell, reset settings
		write_vertex(0, 0, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
		write_vertex(1, 0, 24'sh800000, 24'sh800000, 24'sh800000);
		write_vertex(1, 1, 24'sh000000, 24'sh000000, 24'sh000000);
		write_vertex(0, 1, 24'sh7fffff, 24'sh800000, 24'sh000001);
		generate_raw(0, 0);
		// far corner wraps onto row and column zero
		emit_cell(63, 63);
		// zero-length edges
		for (int k = 0; k < 4; k++)
			write_vertex(10 + k / 2, 10 + (k % 2), 24'sh012345, -24'sh000100, 24'sh000000);
		generate_raw(10, 10);
		drain();

		// no wrap on a small grid: out-of-range write and cell, reused normal
		set_grid(2, 3, 1'b0);
		write_vertex(5, 5, rand_coord(), rand_coord(), rand_coord());
		generate_raw(1, 0);
		generate_raw(0, 0);
		emit_cell(0, 1);
		drain();

		// a single row and column wraps onto itself
		set_grid(1, 1, 1'b1);
		generate_raw(0, 0);
		generate_raw(0, 1);
		drain();

		// empty grid rejects everything
		set_grid(0, 0, 1'b1);
		generate_raw(0, 0);
		write_vertex(0, 0, rand_coord(), rand_coord(), rand_coord());
		drain();

		// random phases over several grid settings
		for (int p = 0; p < 6; p++) begin
			set_grid(phase_rows[p], phase_cols[p], phase_wrap[p]);
			snd_idle = (p < 2) ? 32 : (p < 4) ? 48 : 0;
			rcv_idle = (p < 2) ? 48 : (p < 4) ? 32 : 0;
			if (p == 2)
				hold_req = 1'b1;
			repeat (5) random_request();
			drain();
		end

		$display("sent %0d requests: %0d cells, %0d error records, %0d records checked",
			requests_sent, sb.cells_made, sb.error_records, sb.records_checked);
		$display("grid sizes from empty to full, with and without wrap, long output stall");
		if (fails == 0) begin
			$display("PASS grid_mesh_triangulator");
		end else begin
			$display("FAIL grid_mesh_triangulator");
		end
		$finish;
	end
endmodule
